[rtl/core/sis_pkg.sv]
`timescale 1ns / 1ps
package sis_pkg;
  localparam int unsigned DefMaxRanges = 16;
  localparam int unsigned DefValueBits = 32;
  localparam int unsigned OutBits = 32;
  localparam int unsigned CountBits = 33;
  localparam int unsigned RcBits = 5;

  localparam logic [1:0] ActAdd = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;
  localparam logic [1:0] ActClear = 2'd3;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StOrder = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [DefValueBits-1:0] low_value;
    logic [DefValueBits-1:0] high_value;
  } sis_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        covered;
    logic        holder_valid;
    logic [31:0] holder_low;
    logic [31:0] holder_high;
    logic [32:0] value_count;
    logic [31:0] lowest;
    logic [31:0] highest;
    logic [4:0]  range_count;
  } sis_rsp_t;
endpackage

[rtl/core/sis_cell.sv]
`timescale 1ns / 1ps
// one slot of the shift chain: holds a range and a valid flag, takes its
// upstream neighbor's contents on shift and is loaded directly on write
module sis_cell #(
  parameter int unsigned ValueBits = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 shift_i,
  input  logic                 up_vld_i,
  input  logic [ValueBits-1:0] up_lo_i,
  input  logic [ValueBits-1:0] up_hi_i,
  input  logic                 load_i,
  input  logic                 load_vld_i,
  input  logic [ValueBits-1:0] load_lo_i,
  input  logic [ValueBits-1:0] load_hi_i,
  output logic                 vld_o,
  output logic [ValueBits-1:0] lo_o,
  output logic [ValueBits-1:0] hi_o
);
  logic                 vld_q;
  logic [ValueBits-1:0] lo_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= load_vld_i;
    end else if (shift_i) begin
      vld_q <= up_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_q <= load_lo_i;
      hi_q <= load_hi_i;
    end else if (shift_i) begin
      lo_q <= up_lo_i;
      hi_q <= up_hi_i;
    end
  end

  assign vld_o = vld_q;
  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
endmodule

[rtl/core/sorted_interval_set_unit.sv]
`timescale 1ns / 1ps
// sorted interval set: a table of disjoint, non-touching ranges in a chain of
// cells that rotates by one slot each cycle during a pass unless it stalls.
// a transaction is accepted when start is high and busy is low; req_i
// carries action, low and high. exactly one result follows, shown on rsp_o
// for one cycle with done_o high; the receiver cannot stall it.
// add and remove rotate the whole chain once: at each step the head cell is
// read, merged or cut against the operand, and the pieces enter at the tail;
// when one step yields two pieces, the second is held and the ring stalls.
// query also takes one full pass; clear does not rotate the chain.
// clear, and add or remove with low above high, go straight to the result;
// one transaction at a time: busy stays high until the result has been shown.
// a full-table rejection restores the old table since the rotation returns
// every original entry; pieces are staged in a shadow chain and copied on
// success. stored entries sit at the tail end of the chain, in order.
// reset empties the table (all cells invalid) and zeroes the value count.
module sorted_interval_set_unit
  import sis_pkg::*;
#(
  parameter int unsigned MaxRanges = sis_pkg::DefMaxRanges
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  sis_pkg::sis_req_t   req_i,
  output logic                busy,
  output logic                done_o,
  output sis_pkg::sis_rsp_t   rsp_o
);
  localparam int unsigned ValueBits = DefValueBits;
  localparam int unsigned NB = $clog2(MaxRanges + 1);
  localparam int unsigned IB = $clog2(MaxRanges);
  localparam int unsigned CB = ValueBits + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [1:0]           act_q;
  logic [ValueBits-1:0] op_lo_q, op_hi_q, nlo_q, nhi_q;
  logic                 placed_q, pend_q;
  logic [ValueBits-1:0] pend_lo_q, pend_hi_q;
  logic [IB:0]          step_q;
  logic [NB-1:0]        used_q, n_q;
  logic                 over_q;
  logic [CB-1:0]        total_q, sum_q;
  logic                 hv_q;
  logic [ValueBits-1:0] hlo_q, hhi_q;
  sis_rsp_t             rsp_q;
  logic                 done_q;

  // main ring and shadow (output) chain
  logic                 m_vld [MaxRanges];
  logic [ValueBits-1:0] m_lo  [MaxRanges];
  logic [ValueBits-1:0] m_hi  [MaxRanges];
  logic                 s_vld [MaxRanges];
  logic [ValueBits-1:0] s_lo  [MaxRanges];
  logic [ValueBits-1:0] s_hi  [MaxRanges];
  // shadow chain as it stands after this cycle's shift
  logic                 s_nv  [MaxRanges];
  logic [ValueBits-1:0] s_nlo [MaxRanges];
  logic [ValueBits-1:0] s_nhi [MaxRanges];

  logic                 m_shift, s_shift, s_clear, m_clear, commit;
  logic                 s_in_vld;
  logic [ValueBits-1:0] s_in_lo, s_in_hi;

  wire                  accept = start && !busy;
  wire [ValueBits-1:0]  h_lo = m_lo[0];
  wire [ValueBits-1:0]  h_hi = m_hi[0];
  wire                  h_v  = m_vld[0];
  wire                  scanning = state_q == S_SCAN;

  for (genvar g = 0; g < MaxRanges; g++) begin : g_cells
    assign s_nv[g]  = s_shift ? (g == MaxRanges-1 ? s_in_vld : s_vld[(g+1) % MaxRanges])
                              : s_vld[g];
    assign s_nlo[g] = s_shift ? (g == MaxRanges-1 ? s_in_lo : s_lo[(g+1) % MaxRanges])
                              : s_lo[g];
    assign s_nhi[g] = s_shift ? (g == MaxRanges-1 ? s_in_hi : s_hi[(g+1) % MaxRanges])
                              : s_hi[g];
    sis_cell #(.ValueBits(ValueBits)) u_m (
      .clk_i, .rst_ni, .clear_i(m_clear), .shift_i(m_shift),
      .up_vld_i  (g == MaxRanges-1 ? m_vld[0] : m_vld[(g+1) % MaxRanges]),
      .up_lo_i   (g == MaxRanges-1 ? m_lo[0]  : m_lo[(g+1) % MaxRanges]),
      .up_hi_i   (g == MaxRanges-1 ? m_hi[0]  : m_hi[(g+1) % MaxRanges]),
      .load_i(commit), .load_vld_i(s_nv[g]), .load_lo_i(s_nlo[g]),
      .load_hi_i(s_nhi[g]),
      .vld_o(m_vld[g]), .lo_o(m_lo[g]), .hi_o(m_hi[g]));
    sis_cell #(.ValueBits(ValueBits)) u_s (
      .clk_i, .rst_ni, .clear_i(s_clear), .shift_i(s_shift),
      .up_vld_i  (g == MaxRanges-1 ? s_in_vld : s_vld[(g+1) % MaxRanges]),
      .up_lo_i   (g == MaxRanges-1 ? s_in_lo  : s_lo[(g+1) % MaxRanges]),
      .up_hi_i   (g == MaxRanges-1 ? s_in_hi  : s_hi[(g+1) % MaxRanges]),
      .load_i(1'b0), .load_vld_i(1'b0), .load_lo_i(s_lo[g]),
      .load_hi_i(s_hi[g]),
      .vld_o(s_vld[g]), .lo_o(s_lo[g]), .hi_o(s_hi[g]));
  end

  // per-step classification of the head entry
  logic below, above, add_emit_new, rm_keep, rm_left, rm_right;
  always_comb begin
    below = (h_hi < nlo_q) && ((nlo_q - h_hi) > ValueBits'(1));
    above = (h_lo > nhi_q) && ((h_lo - nhi_q) > ValueBits'(1));
    add_emit_new = above && !placed_q;
    rm_keep  = (h_hi < op_lo_q) || (h_lo > op_hi_q);
    rm_left  = !rm_keep && (h_lo < op_lo_q);
    rm_right = !rm_keep && (h_hi > op_hi_q);
  end

  // push into the shadow chain: at most one piece a cycle, a second one waits
  logic                 push;
  logic [ValueBits-1:0] push_lo, push_hi;
  logic                 pend_d;
  logic [ValueBits-1:0] pend_lo_d, pend_hi_d, nlo_d, nhi_d;
  logic                 placed_d, stall;
  always_comb begin
    push = 1'b0; push_lo = h_lo; push_hi = h_hi;
    pend_d = pend_q; pend_lo_d = pend_lo_q; pend_hi_d = pend_hi_q;
    nlo_d = nlo_q; nhi_d = nhi_q; placed_d = placed_q; stall = 1'b0;
    if (scanning) begin
      if (pend_q) begin
        push = 1'b1; push_lo = pend_lo_q; push_hi = pend_hi_q;
        pend_d = 1'b0; stall = 1'b1;
      end else if (h_v && act_q == ActAdd) begin
        if (below) begin
          push = 1'b1;
        end else if (add_emit_new) begin
          push = 1'b1; push_lo = nlo_q; push_hi = nhi_q; placed_d = 1'b1;
          pend_d = 1'b1; pend_lo_d = h_lo; pend_hi_d = h_hi;
        end else if (above) begin
          push = 1'b1;
        end else begin
          if (h_lo < nlo_q) nlo_d = h_lo;
          if (h_hi > nhi_q) nhi_d = h_hi;
        end
      end else if (h_v && act_q == ActRemove) begin
        if (rm_keep) begin
          push = 1'b1;
        end else if (rm_left) begin
          push = 1'b1; push_hi = op_lo_q - ValueBits'(1);
          if (rm_right) begin
            pend_d = 1'b1; pend_lo_d = op_hi_q + ValueBits'(1); pend_hi_d = h_hi;
          end
        end else if (rm_right) begin
          push = 1'b1; push_lo = op_hi_q + ValueBits'(1);
        end
      end
    end else if (state_q == S_FLUSH && act_q == ActAdd && !placed_q) begin
      push = 1'b1; push_lo = nlo_q; push_hi = nhi_q; placed_d = 1'b1;
    end
  end

  assign s_in_vld = 1'b1;
  assign s_in_lo  = push_lo;
  assign s_in_hi  = push_hi;
  wire   s_room   = n_q < NB'(MaxRanges);
  assign s_shift  = push && s_room;
  assign m_shift  = scanning && !stall;
  assign s_clear  = accept;
  wire   fits     = !over_q && !(push && !s_room);
  // the pass ends once the ring is back home and no held piece remains
  wire [IB:0] step_nx = step_q + (IB+1)'(m_shift);
  wire   last     = scanning && !pend_d && (step_nx == (IB+1)'(MaxRanges));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) begin
        state_d = ((req_i.action == ActClear)
                   || (req_i.action != ActQuery
                       && req_i.low_value[ValueBits-1:0] > req_i.high_value[ValueBits-1:0]))
                  ? S_DONE : S_SCAN;
      end
      S_SCAN:  if (last)
                 state_d = S_FLUSH;
      S_FLUSH: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign commit  = state_q == S_FLUSH && act_q != ActQuery && fits;
  assign m_clear = accept && req_i.action == ActClear;

  wire [CB-1:0] piece = CB'(push_hi) - CB'(push_lo) + CB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == S_DONE;
      pend_q  <= accept ? 1'b0 : pend_d;
      if (m_clear) begin
        used_q  <= '0;
        total_q <= '0;
      end else if (commit) begin
        used_q  <= n_q + NB'(s_shift);
        total_q <= sum_q + (s_shift ? piece : '0);
      end
    end
  end

  // entries are packed against the tail, so the first one sits used_q from the end
  logic [ValueBits-1:0] lo_first;
  always_comb begin
    lo_first = m_lo[0];
    for (int k = 0; k < MaxRanges; k++)
      if (NB'(MaxRanges - k) == used_q) lo_first = m_lo[k];
  end

  logic [1:0] st_w;
  always_ff @(posedge clk_i) begin
    pend_lo_q <= pend_lo_d;
    pend_hi_q <= pend_hi_d;
    if (accept) begin
      act_q    <= req_i.action;
      op_lo_q  <= req_i.low_value[ValueBits-1:0];
      op_hi_q  <= req_i.high_value[ValueBits-1:0];
      nlo_q    <= req_i.low_value[ValueBits-1:0];
      nhi_q    <= req_i.high_value[ValueBits-1:0];
      placed_q <= 1'b0;
      step_q   <= '0;
      n_q      <= '0;
      sum_q    <= '0;
      over_q   <= 1'b0;
      hv_q     <= 1'b0;
      hlo_q    <= '0;
      hhi_q    <= '0;
    end else begin
      nlo_q    <= nlo_d;
      nhi_q    <= nhi_d;
      placed_q <= placed_d;
      if (m_shift) step_q <= step_q + (IB+1)'(1);
      if (s_shift) begin
        n_q   <= n_q + NB'(1);
        sum_q <= sum_q + piece;
      end
      if (push && !s_room) over_q <= 1'b1;
      if (scanning && !stall && h_v && act_q == ActQuery
          && h_lo <= op_lo_q && h_hi >= op_lo_q) begin
        hv_q <= 1'b1; hlo_q <= h_lo; hhi_q <= h_hi;
      end
    end
    if (state_q == S_DONE) begin
      rsp_q.status       <= st_w;
      rsp_q.covered      <= act_q == ActQuery && !(op_lo_q > op_hi_q)
                            && hv_q && hhi_q >= op_hi_q;
      rsp_q.holder_valid <= hv_q;
      rsp_q.holder_low   <= OutBits'(hlo_q);
      rsp_q.holder_high  <= OutBits'(hhi_q);
      rsp_q.value_count  <= CountBits'(total_q);
      rsp_q.lowest       <= used_q != '0 ? OutBits'(lo_first) : '0;
      rsp_q.highest      <= used_q != '0 ? OutBits'(m_hi[MaxRanges-1]) : '0;
      rsp_q.range_count  <= RcBits'(used_q);
    end
  end

  logic full_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (accept) full_q <= 1'b0;
    else if (state_q == S_FLUSH && act_q != ActQuery && !fits) full_q <= 1'b1;
  end

  always_comb begin
    if (act_q == ActClear) st_w = StDone;
    else if (op_lo_q > op_hi_q) st_w = StOrder;
    else if (full_q) st_w = StFull;
    else st_w = StDone;
  end

  assign busy   = state_q != S_IDLE || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> busy) else $error("ready while working");
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= NB'(MaxRanges)) else $error("entry count overflow");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_DONE) else $error("stray result");
endmodule
